// File: design/mvnb_pkg.sv
// shared types and constants of the vertex normal builder
package mvnb_pkg;

   localparam int IDX_BITS         = 12;
   localparam int COORD_W          = 24;
   localparam int NORM_W           = 16;
   localparam int DEF_MAX_VERTICES = 4096;
   localparam int DEF_COORD_BITS   = 24;
   localparam int CMD_DEPTH        = 2;
   localparam int RSP_DEPTH        = 2;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_TRI  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_TRI,
      KIND_READ,
      KIND_READ_OOR
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]                 op;
      logic [IDX_BITS-1:0]        index_a;
      logic [IDX_BITS-1:0]        index_b;
      logic [IDX_BITS-1:0]        index_c;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic signed [COORD_W-1:0]  pos_z;
   } req_word_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
      logic                     degenerate;
      logic                     saturated;
   } rsp_word_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic [IDX_BITS-1:0]        index_a;
      logic [IDX_BITS-1:0]        index_b;
      logic [IDX_BITS-1:0]        index_c;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic signed [COORD_W-1:0]  pos_z;
   } cmd_word_type;

endpackage

// File: design/mvnb_fifo.sv
// small register queue used between the parts of the block
module mvnb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (PW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: design/mvnb_front.sv
// front end: decodes and range-checks incoming words into commands
module mvnb_front import mvnb_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int COORD_BITS   = DEF_COORD_BITS
) (
   input  logic         req_push,
   input  req_word_type req_word,
   output logic         cmd_push,
   output cmd_word_type cmd_word
);

   localparam int SH = COORD_W - COORD_BITS;

   logic in_a, in_b, in_c;

   function automatic logic signed [COORD_W-1:0] coord_extend(input logic [COORD_W-1:0] raw);
      logic [COORD_W-1:0] up;
      up = raw << SH;
      return $signed(up) >>> SH;
   endfunction

   assign in_a = (32'(req_word.index_a) < MAX_VERTICES);
   assign in_b = (32'(req_word.index_b) < MAX_VERTICES);
   assign in_c = (32'(req_word.index_c) < MAX_VERTICES);

   always_comb begin
      cmd_word.kind    = KIND_LOAD;
      cmd_word.index_a = req_word.index_a;
      cmd_word.index_b = req_word.index_b;
      cmd_word.index_c = req_word.index_c;
      cmd_word.pos_x   = coord_extend(req_word.pos_x);
      cmd_word.pos_y   = coord_extend(req_word.pos_y);
      cmd_word.pos_z   = coord_extend(req_word.pos_z);
      cmd_push         = 1'b0;
      case (req_word.op)
         OP_LOAD: begin
            cmd_word.kind = KIND_LOAD;
            cmd_push      = req_push && in_a;
         end
         OP_TRI: begin
            cmd_word.kind = KIND_TRI;
            cmd_push      = req_push && in_a && in_b && in_c;
         end
         OP_READ: begin
            // out of range read still answers, as a degenerate normal
            cmd_word.kind = in_a ? KIND_READ : KIND_READ_OOR;
            cmd_push      = req_push;
         end
         default: begin
            cmd_push = 1'b0;
         end
      endcase
   end

endmodule

// File: design/mvnb_back.sv
// back end: vertex and accumulator memories, cross product and normalizer
module mvnb_back import mvnb_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_empty,
   output logic         cmd_pop,
   input  cmd_word_type cmd_word,
   input  logic         rsp_full,
   output logic         rsp_push,
   output rsp_word_type rsp_word
);

   localparam int DEPTH = (MAX_VERTICES < 2**IDX_BITS) ? MAX_VERTICES : 2**IDX_BITS;
   localparam int AW    = $clog2(DEPTH);
   localparam int VW    = 3 * COORD_W;
   localparam int EW    = COORD_W + 1;
   localparam int PRW   = 2 * EW;
   localparam int NW    = PRW + 1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_VA, ST_VB, ST_VC, ST_E2, ST_MUL, ST_ACC_RD, ST_ACC_WR,
      ST_RD, ST_RD_CHK, ST_SHIFT, ST_SQ, ST_SQRT, ST_DIV_INIT, ST_DIV, ST_DONE
   } state_type;

   state_type    state_ff, state_in;
   cmd_word_type cmd_ff, cmd_in;
   logic [VW-1:0] pa_ff, pa_in;
   logic signed [EW-1:0] e1x_ff, e1y_ff, e1z_ff, e2x_ff, e2y_ff, e2z_ff;
   logic signed [EW-1:0] e1x_in, e1y_in, e1z_in, e2x_in, e2y_in, e2z_in;
   logic signed [PRW-1:0] prod_ff, prod_in;
   logic signed [NW-1:0]  nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  corner_ff, corner_in;
   logic [63:0] mag0_ff, mag1_ff, mag2_ff, mag0_in, mag1_in, mag2_in;
   logic        neg0_ff, neg1_ff, neg2_ff, neg0_in, neg1_in, neg2_in;
   logic [61:0] sq_ff, sq_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] root_ff, root_in;
   logic [63:0] bit_ff, bit_in;
   logic [49:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [15:0] quo_ff, quo_in;
   logic [NORM_W-1:0] res0_ff, res1_ff, res2_ff, res0_in, res1_in, res2_in;
   logic        degen_ff, degen_in, sat_ff, sat_in;

   // memories
   logic [VW-1:0] vmem [DEPTH];
   logic [63:0]   sxmem [DEPTH];
   logic [63:0]   symem [DEPTH];
   logic [63:0]   szmem [DEPTH];
   logic          satmem [DEPTH];
   logic [VW-1:0] vrd_ff;
   logic [63:0]   sxr_ff, syr_ff, szr_ff;
   logic          satr_ff;
   logic [AW-1:0] v_addr, s_addr;
   logic          v_we, s_we;
   logic [VW-1:0] v_wd;
   logic [63:0]   sx_wd, sy_wd, sz_wd;
   logic          sat_wd;

   logic signed [EW-1:0] mul_a, mul_b;
   logic [64:0] add_x, add_y, add_z;
   logic [63:0] trial;
   logic        ge;
   logic [16:0] q_full;
   logic [NORM_W-1:0] q_out;

   function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      logic        ovf;
      s   = a + b;
      ovf = (a[63] == b[63]) && (s[63] != a[63]);
      if (ovf) begin
         return {1'b1, b[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}}};
      end
      return {1'b0, s};
   endfunction

   function automatic logic signed [EW-1:0] coord_diff(input logic [COORD_W-1:0] p,
                                                       input logic [COORD_W-1:0] q);
      return $signed({p[COORD_W-1], p}) - $signed({q[COORD_W-1], q});
   endfunction

   assign rsp_word.normal_x   = res0_ff;
   assign rsp_word.normal_y   = res1_ff;
   assign rsp_word.normal_z   = res2_ff;
   assign rsp_word.degenerate = degen_ff;
   assign rsp_word.saturated  = sat_ff;

   assign cmd_pop  = (state_ff == ST_IDLE) && !cmd_empty;
   assign rsp_push = (state_ff == ST_DONE) && !rsp_full;

   // cross product operand pairs, one product a cycle
   always_comb begin
      case (cnt_ff[2:0])
         3'd0: begin mul_a = e1y_ff; mul_b = e2z_ff; end
         3'd1: begin mul_a = e1z_ff; mul_b = e2y_ff; end
         3'd2: begin mul_a = e1z_ff; mul_b = e2x_ff; end
         3'd3: begin mul_a = e1x_ff; mul_b = e2z_ff; end
         3'd4: begin mul_a = e1x_ff; mul_b = e2y_ff; end
         3'd5: begin mul_a = e1y_ff; mul_b = e2x_ff; end
         default: begin mul_a = e1x_ff; mul_b = e2x_ff; end
      endcase
   end

   assign add_x  = sat_add(sxr_ff, 64'(nx_ff));
   assign add_y  = sat_add(syr_ff, 64'(ny_ff));
   assign add_z  = sat_add(szr_ff, 64'(nz_ff));
   assign trial  = root_ff + bit_ff;
   assign ge     = (rem_ff >= dsh_ff);
   assign q_full = {quo_ff, ge};
   always_comb begin
      if (neg0_ff) begin
         q_out = NORM_W'(17'd0 - q_full);
      end else if (q_full > 17'd32767) begin
         q_out = 16'h7fff;
      end else begin
         q_out = q_full[NORM_W-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      pa_in     = pa_ff;
      e1x_in = e1x_ff; e1y_in = e1y_ff; e1z_in = e1z_ff;
      e2x_in = e2x_ff; e2y_in = e2y_ff; e2z_in = e2z_ff;
      prod_in   = prod_ff;
      nx_in = nx_ff; ny_in = ny_ff; nz_in = nz_ff;
      cnt_in    = cnt_ff;
      corner_in = corner_ff;
      mag0_in = mag0_ff; mag1_in = mag1_ff; mag2_in = mag2_ff;
      neg0_in = neg0_ff; neg1_in = neg1_ff; neg2_in = neg2_ff;
      sq_in     = sq_ff;
      acc_in    = acc_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      quo_in    = quo_ff;
      res0_in = res0_ff; res1_in = res1_ff; res2_in = res2_ff;
      degen_in  = degen_ff;
      sat_in    = sat_ff;
      v_addr = cmd_ff.index_a[AW-1:0];
      s_addr = cmd_ff.index_a[AW-1:0];
      v_we   = 1'b0;
      s_we   = 1'b0;
      v_wd   = {cmd_ff.pos_x, cmd_ff.pos_y, cmd_ff.pos_z};
      sx_wd  = '0;
      sy_wd  = '0;
      sz_wd  = '0;
      sat_wd = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_in = cmd_word;
               case (cmd_word.kind)
                  KIND_LOAD: state_in = ST_LOAD;
                  KIND_TRI:  state_in = ST_VA;
                  KIND_READ: state_in = ST_RD;
                  default: begin
                     res0_in  = '0;
                     res1_in  = '0;
                     res2_in  = '0;
                     degen_in = 1'b1;
                     sat_in   = 1'b0;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            v_we     = 1'b1;
            s_we     = 1'b1;
            state_in = ST_IDLE;
         end
         ST_VA: begin
            state_in = ST_VB;
         end
         ST_VB: begin
            v_addr   = cmd_ff.index_b[AW-1:0];
            pa_in    = vrd_ff;
            state_in = ST_VC;
         end
         ST_VC: begin
            v_addr   = cmd_ff.index_c[AW-1:0];
            e1x_in   = coord_diff(vrd_ff[VW-1 -: COORD_W], pa_ff[VW-1 -: COORD_W]);
            e1y_in   = coord_diff(vrd_ff[2*COORD_W-1 -: COORD_W], pa_ff[2*COORD_W-1 -: COORD_W]);
            e1z_in   = coord_diff(vrd_ff[COORD_W-1:0], pa_ff[COORD_W-1:0]);
            state_in = ST_E2;
         end
         ST_E2: begin
            e2x_in   = coord_diff(vrd_ff[VW-1 -: COORD_W], pa_ff[VW-1 -: COORD_W]);
            e2y_in   = coord_diff(vrd_ff[2*COORD_W-1 -: COORD_W], pa_ff[2*COORD_W-1 -: COORD_W]);
            e2z_in   = coord_diff(vrd_ff[COORD_W-1:0], pa_ff[COORD_W-1:0]);
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (cnt_ff < 6'd6) begin
               prod_in = mul_a * mul_b;
            end
            // fold in the product of the previous cycle
            case (cnt_ff)
               6'd1: nx_in = NW'(prod_ff);
               6'd2: nx_in = nx_ff - NW'(prod_ff);
               6'd3: ny_in = NW'(prod_ff);
               6'd4: ny_in = ny_ff - NW'(prod_ff);
               6'd5: nz_in = NW'(prod_ff);
               6'd6: nz_in = nz_ff - NW'(prod_ff);
               default: nx_in = nx_ff;
            endcase
            if (cnt_ff == 6'd6) begin
               corner_in = '0;
               state_in  = ST_ACC_RD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ACC_RD, ST_ACC_WR: begin
            case (corner_ff)
               2'd0:    s_addr = cmd_ff.index_a[AW-1:0];
               2'd1:    s_addr = cmd_ff.index_b[AW-1:0];
               default: s_addr = cmd_ff.index_c[AW-1:0];
            endcase
            if (state_ff == ST_ACC_RD) begin
               state_in = ST_ACC_WR;
            end else begin
               s_we   = 1'b1;
               sx_wd  = add_x[63:0];
               sy_wd  = add_y[63:0];
               sz_wd  = add_z[63:0];
               sat_wd = satr_ff | add_x[64] | add_y[64] | add_z[64];
               if (corner_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end else begin
                  corner_in = corner_ff + 1'b1;
                  state_in  = ST_ACC_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_RD_CHK;
         end
         ST_RD_CHK: begin
            sat_in = satr_ff;
            if (sxr_ff == '0 && syr_ff == '0 && szr_ff == '0) begin
               res0_in  = '0;
               res1_in  = '0;
               res2_in  = '0;
               degen_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               degen_in = 1'b0;
               neg0_in  = sxr_ff[63];
               neg1_in  = syr_ff[63];
               neg2_in  = szr_ff[63];
               mag0_in  = sxr_ff[63] ? 64'd0 - sxr_ff : sxr_ff;
               mag1_in  = syr_ff[63] ? 64'd0 - syr_ff : syr_ff;
               mag2_in  = szr_ff[63] ? 64'd0 - szr_ff : szr_ff;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // one bit a cycle until the largest magnitude fits in 31 bits
            if ((mag0_ff[63:31] | mag1_ff[63:31] | mag2_ff[63:31]) != '0) begin
               mag0_in = mag0_ff >> 1;
               mag1_in = mag1_ff >> 1;
               mag2_in = mag2_ff >> 1;
            end else begin
               cnt_in   = '0;
               acc_in   = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (cnt_ff < 6'd3) begin
               sq_in   = mag0_ff[30:0] * mag0_ff[30:0];
               mag0_in = mag1_ff;
               mag1_in = mag2_ff;
               mag2_in = mag0_ff;
               neg0_in = neg1_ff;
               neg1_in = neg2_ff;
               neg2_in = neg0_ff;
            end
            if (cnt_ff != '0) begin
               acc_in = acc_ff + 64'(sq_ff);
            end
            if (cnt_ff == 6'd3) begin
               cnt_in   = '0;
               root_in  = '0;
               bit_in   = 64'd1 << 62;
               state_in = ST_SQRT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            if (acc_ff >= trial) begin
               acc_in  = acc_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd31) begin
               corner_in = '0;
               state_in  = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            rem_in   = 50'({mag0_ff[30:0], 16'b0}) + 50'(root_ff[31:0]);
            dsh_in   = 50'({root_ff[31:0], 1'b0}) << 16;
            quo_in   = '0;
            cnt_in   = 6'd16;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            dsh_in = dsh_ff >> 1;
            quo_in = q_full[15:0];
            if (cnt_ff == '0) begin
               res0_in = res1_ff;
               res1_in = res2_ff;
               res2_in = q_out;
               mag0_in = mag1_ff;
               mag1_in = mag2_ff;
               mag2_in = mag0_ff;
               neg0_in = neg1_ff;
               neg1_in = neg2_ff;
               neg2_in = neg0_ff;
               if (corner_ff == 2'd2) begin
                  state_in = ST_DONE;
               end else begin
                  corner_in = corner_ff + 1'b1;
                  state_in  = ST_DIV_INIT;
               end
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff    <= cmd_in;
      pa_ff     <= pa_in;
      e1x_ff <= e1x_in; e1y_ff <= e1y_in; e1z_ff <= e1z_in;
      e2x_ff <= e2x_in; e2y_ff <= e2y_in; e2z_ff <= e2z_in;
      prod_ff   <= prod_in;
      nx_ff <= nx_in; ny_ff <= ny_in; nz_ff <= nz_in;
      cnt_ff    <= cnt_in;
      corner_ff <= corner_in;
      mag0_ff <= mag0_in; mag1_ff <= mag1_in; mag2_ff <= mag2_in;
      neg0_ff <= neg0_in; neg1_ff <= neg1_in; neg2_ff <= neg2_in;
      sq_ff     <= sq_in;
      acc_ff    <= acc_in;
      root_ff   <= root_in;
      bit_ff    <= bit_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      quo_ff    <= quo_in;
      res0_ff <= res0_in; res1_ff <= res1_in; res2_ff <= res2_in;
      degen_ff  <= degen_in;
      sat_ff    <= sat_in;
   end

   always_ff @(posedge clock) begin
      if (v_we) begin
         vmem[v_addr] <= v_wd;
      end
      vrd_ff <= vmem[v_addr];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         sxmem[s_addr]  <= sx_wd;
         symem[s_addr]  <= sy_wd;
         szmem[s_addr]  <= sz_wd;
         satmem[s_addr] <= sat_wd;
      end
      sxr_ff  <= sxmem[s_addr];
      syr_ff  <= symem[s_addr];
      szr_ff  <= szmem[s_addr];
      satr_ff <= satmem[s_addr];
   end

`ifndef SYNTHESIS
   a_tri_starts_fetch: assert property (@(posedge clock) disable iff (reset)
      cmd_pop && cmd_word.kind == KIND_TRI |=> state_ff == ST_VA)
      else $error("triangle command did not start vertex fetch");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_INIT |-> root_ff[31:0] != '0)
      else $error("zero length reached the divider");

   a_quotient_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && cnt_ff == '0 |-> q_full <= 17'd32768)
      else $error("normal component quotient out of range");

   a_mags_narrow: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQ |-> (mag0_ff[63:31] | mag1_ff[63:31] | mag2_ff[63:31]) == '0)
      else $error("magnitudes not reduced before squaring");
`endif

endmodule

// File: design/mesh_vertex_normal_builder_core.sv
// top level of the vertex normal builder
//
// channels: request queue (req_push / req_full, req_word) and response queue
// (rsp_empty / rsp_pop, rsp_word). op 0 loads a vertex and clears its normal
// sum, op 1 adds a triangle's cross product into its three corners with
// saturation, op 2 returns the normalized sum of one vertex in Q1.15.
// only op 2 produces a response word; op 3 and out-of-range load or triangle
// words are dropped, an out-of-range read answers with a degenerate zero normal.
// a two-entry command queue parts the decoder from the execution sequencer.
// at the sequencer a load writes the vertex and clears its sums; a triangle
// makes three vertex reads, six products through one multiplier and three
// read-modify-writes of the single-port accumulator memories; a read shifts
// its sum magnitudes right one bit at a time while the largest exceeds 31
// bits; a 32-step square root and three 17-step dividers dominate its work.
// reset empties both queues and idles the sequencer; memories are not cleared,
// so a vertex must be loaded before use. when the receiver stalls, finished
// responses wait in a two-entry response queue and the sequencer holds its
// next response until a slot frees.
module mesh_vertex_normal_builder_core import mvnb_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int COORD_BITS   = DEF_COORD_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  req_word_type req_word,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_word_type rsp_word
);

   logic         dec_push;
   cmd_word_type dec_word;
   logic         cmd_empty, cmd_pop;
   cmd_word_type cmd_word;
   logic         rsp_full, rsp_push;
   rsp_word_type seq_word;

   mvnb_front #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_front (
      .req_push (req_push),
      .req_word (req_word),
      .cmd_push (dec_push),
      .cmd_word (dec_word)
   );

   mvnb_fifo #(
      .WIDTH ($bits(cmd_word_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (dec_push),
      .wdata (dec_word),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (cmd_word),
      .empty (cmd_empty)
   );

   mvnb_back #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_word  (cmd_word),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_word  (seq_word)
   );

   mvnb_fifo #(
      .WIDTH ($bits(rsp_word_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (seq_word),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_word),
      .empty (rsp_empty)
   );

endmodule
